// ----- rtl/ptpd_pkg.sv -----
// Shared types and constants for the point transform with perspective divide.
// No dependencies; imported by the row, divider and top-level modules.
package ptpd_pkg;

  localparam int DATA_W    = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_C01 = 4'd0,
    REG_ROW0_C23 = 4'd1,
    REG_ROW1_C01 = 4'd2,
    REG_ROW1_C23 = 4'd3,
    REG_ROW2_C01 = 4'd4,
    REG_ROW2_C23 = 4'd5,
    REG_ROW3_C01 = 4'd6,
    REG_ROW3_C23 = 4'd7
  } reg_idx_e;

  // Result of one matrix row: clamped sum and its clamp flag.
  typedef struct packed {
    logic signed [DATA_W-1:0] sum;
    logic                     sat;
  } row_res_t;

endpackage

// ----- rtl/ptpd_row.sv -----
// One matrix row: three products, their exact sum, floor shift, offset and clamp.
// Depends on ptpd_pkg; three register stages.
module ptpd_row #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] x_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] y_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] z_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] c0_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] c1_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] c2_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] c3_i,
  output ptpd_pkg::row_res_t               res_o
);
  import ptpd_pkg::*;

  localparam logic signed [65:0] MAX_V = 66'sd2147483647;
  localparam logic signed [65:0] MIN_V = -66'sd2147483648;

  logic signed [63:0] p0_q, p1_q, p2_q;
  logic signed [65:0] s_q;
  logic signed [DATA_W-1:0] c3a_q, c3b_q;
  logic signed [65:0] t_d;
  row_res_t res_q;

  // Stage one: the three coordinate products.
  always_ff @(posedge clk_i) begin
    p0_q  <= 64'(x_i) * 64'(c0_i);
    p1_q  <= 64'(y_i) * 64'(c1_i);
    p2_q  <= 64'(z_i) * 64'(c2_i);
    c3a_q <= c3_i;
  end

  // Stage two: exact sum of the products.
  always_ff @(posedge clk_i) begin
    s_q   <= 66'(p0_q) + 66'(p1_q) + 66'(p2_q);
    c3b_q <= c3a_q;
  end

  // Stage three: drop the fraction bits towards minus infinity, add the offset, clamp.
  assign t_d = (s_q >>> FRAC_BITS) + 66'(c3b_q);

  always_ff @(posedge clk_i) begin
    if (t_d > MAX_V) begin
      res_q.sum <= 32'sh7fff_ffff;
      res_q.sat <= 1'b1;
    end else if (t_d < MIN_V) begin
      res_q.sum <= 32'sh8000_0000;
      res_q.sat <= 1'b1;
    end else begin
      res_q.sum <= t_d[DATA_W-1:0];
      res_q.sat <= 1'b0;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/ptpd_div.sv -----
// Pipelined restoring divider: (v << FRAC_BITS) / w, truncated towards zero, clamped.
// Depends on ptpd_pkg; one quotient bit a stage, then a final sign and clamp stage.
module ptpd_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] v_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0] w_i,
  output logic signed [ptpd_pkg::DATA_W-1:0] q_o,
  output logic                               sat_o
);
  import ptpd_pkg::*;

  localparam int NW = DATA_W + FRAC_BITS;
  localparam logic [NW-1:0] LIM = {{(NW-DATA_W){1'b0}}, 32'h8000_0000};

  logic [DATA_W-1:0] vmag, wmag;
  logic [DATA_W-1:0] rem_q [NW];
  logic [NW-1:0]     nq_q  [NW];
  logic [DATA_W-1:0] d_q   [NW];
  logic              neg_q [NW];
  logic [NW-1:0]     mag;
  logic signed [DATA_W-1:0] q_q;
  logic              sat_q;

  // Magnitudes and quotient sign of the operands.
  assign vmag = v_i[DATA_W-1] ? DATA_W'(-v_i) : DATA_W'(v_i);
  assign wmag = w_i[DATA_W-1] ? DATA_W'(-w_i) : DATA_W'(w_i);

  // One shift-and-subtract step in each stage; quotient bits shift into the numerator.
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DATA_W-1:0] rem_in;
    logic [NW-1:0]     nq_in;
    logic [DATA_W-1:0] d_in;
    logic              neg_in;
    logic [DATA_W:0]   trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = {vmag, {FRAC_BITS{1'b0}}};
      assign d_in   = wmag;
      assign neg_in = v_i[DATA_W-1] ^ w_i[DATA_W-1];
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign nq_in  = nq_q[i-1];
      assign d_in   = d_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? DATA_W'(trial - {1'b0, d_in}) : trial[DATA_W-1:0];
      nq_q[i]  <= {nq_in[NW-2:0], ge};
      d_q[i]   <= d_in;
      neg_q[i] <= neg_in;
    end
  end

  // Apply the sign and clamp to the 32-bit range.
  assign mag = nq_q[NW-1];

  always_ff @(posedge clk_i) begin
    if (neg_q[NW-1]) begin
      sat_q <= mag > LIM;
      q_q   <= (mag > LIM) ? 32'sh8000_0000 : DATA_W'(-mag);
    end else begin
      sat_q <= mag >= LIM;
      q_q   <= (mag >= LIM) ? 32'sh7fff_ffff : mag[DATA_W-1:0];
    end
  end

  assign q_o   = q_q;
  assign sat_o = sat_q;

endmodule

// ----- rtl/point_transform_perspective_divide.sv -----
// Top level of the 4x4 homogeneous point transform with perspective divide.
// Depends on ptpd_pkg, ptpd_row and ptpd_div.
//
// Use: a point word (in_x_i, in_y_i, in_z_i) is taken at each rising edge with
// start_i high and busy_o low. busy_o is never raised, so a point may be given
// in every cycle. Each point yields one result word on out_*_o, divided_o and
// saturated_o, marked by done_o for exactly one cycle.
// The pipeline has three stages of row multiply-accumulate, then one stage per
// quotient bit in the pipelined dividers and a final sign and clamp stage.
// Throughput is one point per cycle.
// The matrix is written through the cfg channel (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i); cfg_ready_o is always high and indexes beyond the
// eight registers are ignored. Writes should be made while no point is in
// flight.
// Reset clears the pipeline valid bits and loads the identity matrix. The
// receiver cannot stall: every result is presented once and must be taken.
module point_transform_perspective_divide #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [ptpd_pkg::DATA_W-1:0]    in_x_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0]    in_y_i,
  input  logic signed [ptpd_pkg::DATA_W-1:0]    in_z_i,
  output logic                                  done_o,
  output logic signed [ptpd_pkg::DATA_W-1:0]    out_x_o,
  output logic signed [ptpd_pkg::DATA_W-1:0]    out_y_o,
  output logic signed [ptpd_pkg::DATA_W-1:0]    out_z_o,
  output logic signed [ptpd_pkg::DATA_W-1:0]    out_w_o,
  output logic                                  divided_o,
  output logic                                  saturated_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ptpd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ptpd_pkg::CFG_W-1:0]            cfg_data_i
);
  import ptpd_pkg::*;

  localparam int ROW_LAT = 3;
  localparam int DIV_LAT = DATA_W + FRAC_BITS + 1;
  localparam int LAT     = ROW_LAT + DIV_LAT;
  localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

  logic [CFG_W-1:0] m_q [NUM_REGS];
  logic             vld_q [LAT];
  row_res_t         row_res [4];
  logic signed [DATA_W-1:0] q [3];
  logic             qsat [3];
  logic signed [DATA_W-1:0] x_dl_q [DIV_LAT];
  logic signed [DATA_W-1:0] y_dl_q [DIV_LAT];
  logic signed [DATA_W-1:0] z_dl_q [DIV_LAT];
  logic signed [DATA_W-1:0] w_dl_q [DIV_LAT];
  logic             div_dl_q [DIV_LAT];
  logic             sat_dl_q [DIV_LAT];
  logic             row_sat;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Matrix registers, loaded with the identity at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q[0] <= ONE;
      m_q[1] <= '0;
      m_q[2] <= ONE << 32;
      m_q[3] <= '0;
      m_q[4] <= '0;
      m_q[5] <= ONE;
      m_q[6] <= '0;
      m_q[7] <= ONE << 32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROW0_C01: m_q[0] <= cfg_data_i;
        REG_ROW0_C23: m_q[1] <= cfg_data_i;
        REG_ROW1_C01: m_q[2] <= cfg_data_i;
        REG_ROW1_C23: m_q[3] <= cfg_data_i;
        REG_ROW2_C01: m_q[4] <= cfg_data_i;
        REG_ROW2_C23: m_q[5] <= cfg_data_i;
        REG_ROW3_C01: m_q[6] <= cfg_data_i;
        REG_ROW3_C23: m_q[7] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Four row units, one per output coordinate.
  for (genvar r = 0; r < 4; r++) begin : g_row
    ptpd_row #(.FRAC_BITS(FRAC_BITS)) u_row (
      .clk_i (clk_i),
      .x_i   (in_x_i),
      .y_i   (in_y_i),
      .z_i   (in_z_i),
      .c0_i  (m_q[2*r][31:0]),
      .c1_i  (m_q[2*r][63:32]),
      .c2_i  (m_q[2*r+1][31:0]),
      .c3_i  (m_q[2*r+1][63:32]),
      .res_o (row_res[r])
    );
  end

  // Three dividers by w.
  for (genvar k = 0; k < 3; k++) begin : g_div
    ptpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .v_i   (row_res[k].sum),
      .w_i   (row_res[3].sum),
      .q_o   (q[k]),
      .sat_o (qsat[k])
    );
  end

  assign row_sat = row_res[0].sat | row_res[1].sat | row_res[2].sat | row_res[3].sat;

  // Undivided values and flags wait alongside the dividers.
  always_ff @(posedge clk_i) begin
    x_dl_q[0]   <= row_res[0].sum;
    y_dl_q[0]   <= row_res[1].sum;
    z_dl_q[0]   <= row_res[2].sum;
    w_dl_q[0]   <= row_res[3].sum;
    div_dl_q[0] <= row_res[3].sum != '0;
    sat_dl_q[0] <= row_sat;
    for (int i = 1; i < DIV_LAT; i++) begin
      x_dl_q[i]   <= x_dl_q[i-1];
      y_dl_q[i]   <= y_dl_q[i-1];
      z_dl_q[i]   <= z_dl_q[i-1];
      w_dl_q[i]   <= w_dl_q[i-1];
      div_dl_q[i] <= div_dl_q[i-1];
      sat_dl_q[i] <= sat_dl_q[i-1];
    end
  end

  // Pick quotients where w was nonzero, otherwise the undivided row values.
  assign done_o      = vld_q[LAT-1];
  assign divided_o   = div_dl_q[DIV_LAT-1];
  assign out_w_o     = w_dl_q[DIV_LAT-1];
  assign out_x_o     = divided_o ? q[0] : x_dl_q[DIV_LAT-1];
  assign out_y_o     = divided_o ? q[1] : y_dl_q[DIV_LAT-1];
  assign out_z_o     = divided_o ? q[2] : z_dl_q[DIV_LAT-1];
  assign saturated_o = sat_dl_q[DIV_LAT-1] | (divided_o & (qsat[0] | qsat[1] | qsat[2]));

  // A result word reports division exactly when its w is nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (divided_o == (out_w_o != '0)))
    else $error("divided flag disagrees with w");

  // Every result comes from a point taken the full latency earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without matching point");

  // A write to the last matrix register lands on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == REG_ROW3_C23)
      |=> (m_q[7] == $past(cfg_data_i)))
    else $error("matrix register write lost");

endmodule

// ----- tb/point_transform_perspective_divide_test.sv -----
// Self-checking testbench for the 4x4 homogeneous point transform with perspective divide.
// Depends on ptpd_pkg and the point_transform_perspective_divide RTL; needs nothing else.
module point_transform_perspective_divide_test;
  import ptpd_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE   = 32'sh00010000;

  typedef struct {
    logic signed [31:0] x, y, z, w;
    logic               divided, saturated;
  } point_res_t;

  // Matrices used by the directed part.
  typedef enum {MAT_IDENT, MAT_NO_W, MAT_MAX, MAT_MIN, MAT_TINY_W} matrix_e;

  typedef struct {
    matrix_e            mat;
    logic signed [31:0] x, y, z;
    bit                 typed;
    point_res_t         ex;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic signed [31:0] in_x_i = '0, in_y_i = '0, in_z_i = '0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic busy_o, done_o, divided_o, saturated_o, cfg_ready_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o, out_w_o;

  logic [CFG_W-1:0] matrix_q [NUM_REGS];
  point_res_t       pending_q [$];
  int               mismatches = 0;
  int               words_checked = 0;
  int               points_sent = 0;
  int               matrices_loaded = 0;
  bit               calm = 1'b0;
  stim_row_t        directed [18];

  always #10 clk_i = ~clk_i;

  point_transform_perspective_divide dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_x_i, .in_y_i, .in_z_i,
    .done_o, .out_x_o, .out_y_o, .out_z_o, .out_w_o, .divided_o, .saturated_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Coefficient of row r, column k, taken from the shadow copy of the registers.
  function automatic logic signed [31:0] coeff(int r, int k);
    logic [63:0] word;
    word = matrix_q[2 * r + k / 2];
    return (k % 2) ? word[63:32] : word[31:0];
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [67:0] v, inout bit sat);
    if (v > 68'sd2147483647) begin
      sat = 1'b1;
      return S_MAX;
    end
    if (v < -68'sd2147483648) begin
      sat = 1'b1;
      return S_MIN;
    end
    return v[31:0];
  endfunction

  // Exact row sums, floored to the fixed-point grid, then the divide by w.
  function automatic point_res_t transform(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z);
    logic signed [67:0] acc;
    logic signed [31:0] sums [4];
    longint             num;
    bit                 sat;
    point_res_t         res;
    sat = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = longint'(x) * longint'(coeff(r, 0)) + longint'(y) * longint'(coeff(r, 1))
          + longint'(z) * longint'(coeff(r, 2));
      acc = (acc >>> FRAC) + coeff(r, 3);
      sums[r] = clamp(acc, sat);
    end
    res.w = sums[3];
    res.divided = (sums[3] != 0);
    if (res.divided) begin
      for (int r = 0; r < 3; r++) begin
        num = (longint'(sums[r]) * 65536) / longint'(sums[3]);
        sums[r] = clamp(num, sat);
      end
    end
    res.x = sums[0];
    res.y = sums[1];
    res.z = sums[2];
    res.saturated = sat;
    return res;
  endfunction

  function automatic logic signed [31:0] rand_coeff();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return S_MAX;
      2: return S_MIN;
      3: return $urandom;
      4: return ONE * ($urandom_range(0, 8) - 4);
      default: return $urandom_range(0, 1 << 18) - (1 << 17);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1 << 21) - (1 << 20);
      3: return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
      default: return ONE * ($urandom_range(0, 64) - 32);
    endcase
  endfunction

  // Wait until every outstanding word has come back.
  task automatic drain();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Write all eight registers back to back, then one stray index that must be ignored.
  task automatic load_matrix(logic [63:0] m [NUM_REGS]);
    bit rdy;
    drain();
    cfg_valid_i <= 1'b1;
    for (int i = 0; i <= NUM_REGS; i++) begin
      if (i < NUM_REGS) begin
        cfg_index_i <= reg_idx_e'(i);
        cfg_data_i  <= m[i];
      end else begin
        cfg_index_i <= CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7));
        cfg_data_i  <= {$urandom, $urandom};
      end
      do begin
        @(negedge clk_i);
        rdy = cfg_ready_o;
        @(posedge clk_i);
      end while (!rdy);
      if (i < NUM_REGS) matrix_q[i] = m[i];
    end
    cfg_valid_i <= 1'b0;
    matrices_loaded++;
  endtask

  task automatic load_named(matrix_e mat);
    logic [63:0] m [NUM_REGS];
    m[REG_ROW0_C01] = {32'h0, ONE};
    m[REG_ROW0_C23] = '0;
    m[REG_ROW1_C01] = {ONE, 32'h0};
    m[REG_ROW1_C23] = '0;
    m[REG_ROW2_C01] = '0;
    m[REG_ROW2_C23] = {32'h0, ONE};
    m[REG_ROW3_C01] = '0;
    m[REG_ROW3_C23] = {ONE, 32'h0};
    case (mat)
      MAT_NO_W: m[REG_ROW3_C23] = '0;
      MAT_MAX: foreach (m[i]) m[i] = {S_MAX, S_MAX};
      MAT_MIN: foreach (m[i]) m[i] = {S_MIN, S_MIN};
      // w of minus one least significant bit scales each quotient by minus 65536, clamping all but small row values.
      MAT_TINY_W: m[REG_ROW3_C23] = {32'hffffffff, 32'h0};
      default: ;
    endcase
    load_matrix(m);
  endtask

  // Present one point word and hold it until the block takes it.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit typed, point_res_t ex);
    bit taken;
    start_i <= 1'b1;
    in_x_i  <= x;
    in_y_i  <= y;
    in_z_i  <= z;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    pending_q.push_back(typed ? ex : transform(x, y, z));
    points_sent++;
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Result words are stable for the whole cycle, so sample them at the falling edge.
  always @(negedge clk_i) begin
    point_res_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: x=%h y=%h z=%h w=%h",
                                       out_x_o, out_y_o, out_z_o, out_w_o);
      end else begin
        exp_res = pending_q.pop_front();
        words_checked++;
        if (out_x_o !== exp_res.x || out_y_o !== exp_res.y || out_z_o !== exp_res.z ||
            out_w_o !== exp_res.w || divided_o !== exp_res.divided ||
            saturated_o !== exp_res.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Expected x=%h y=%h z=%h w=%h div=%b sat=%b", exp_res.x, exp_res.y,
                     exp_res.z, exp_res.w, exp_res.divided, exp_res.saturated);
            $display("Got      x=%h y=%h z=%h w=%h div=%b sat=%b", out_x_o, out_y_o,
                     out_z_o, out_w_o, divided_o, saturated_o);
          end
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #(20 * 600000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [63:0] m [NUM_REGS];
    point_res_t  none;
    matrix_e     cur;
    none = '{0, 0, 0, 0, 0, 0};

    // Identity and w-free rows have results that can be read off directly.
    directed[0]  = '{MAT_IDENT, 0, 0, 0, 1, '{0, 0, 0, ONE, 1, 0}};
    directed[1]  = '{MAT_IDENT, S_MAX, S_MAX, S_MAX, 1, '{S_MAX, S_MAX, S_MAX, ONE, 1, 0}};
    directed[2]  = '{MAT_IDENT, S_MIN, S_MIN, S_MIN, 1, '{S_MIN, S_MIN, S_MIN, ONE, 1, 0}};
    directed[3]  = '{MAT_IDENT, 1, -1, 32'sh12345678, 1, '{1, -1, 32'sh12345678, ONE, 1, 0}};
    directed[4]  = '{MAT_IDENT, S_MIN, S_MAX, -1, 1, '{S_MIN, S_MAX, -1, ONE, 1, 0}};
    directed[5]  = '{MAT_NO_W, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}};
    directed[6]  = '{MAT_NO_W, S_MAX, S_MIN, 5, 1, '{S_MAX, S_MIN, 5, 0, 0, 0}};
    directed[7]  = '{MAT_NO_W, -1, ONE, 32'sh7fff0000, 1, '{-1, ONE, 32'sh7fff0000, 0, 0, 0}};
    directed[8]  = '{MAT_MAX, S_MAX, S_MAX, S_MAX, 0, none};
    directed[9]  = '{MAT_MAX, S_MIN, S_MIN, S_MIN, 0, none};
    directed[10] = '{MAT_MAX, 1, 1, 1, 0, none};
    directed[11] = '{MAT_MAX, 0, 0, 0, 0, none};
    directed[12] = '{MAT_MIN, S_MAX, S_MIN, S_MAX, 0, none};
    directed[13] = '{MAT_MIN, ONE, 0, 0, 0, none};
    directed[14] = '{MAT_TINY_W, S_MAX, 0, 0, 0, none};
    directed[15] = '{MAT_TINY_W, S_MIN, 1, -ONE, 0, none};
    directed[16] = '{MAT_TINY_W, 0, 0, 0, 0, none};
    directed[17] = '{MAT_TINY_W, 7, -7, ONE, 0, none};

    // The shadow copy starts as the identity that reset loads.
    matrix_q[REG_ROW0_C01] = {32'h0, ONE};
    matrix_q[REG_ROW0_C23] = '0;
    matrix_q[REG_ROW1_C01] = {ONE, 32'h0};
    matrix_q[REG_ROW1_C23] = '0;
    matrix_q[REG_ROW2_C01] = '0;
    matrix_q[REG_ROW2_C23] = {32'h0, ONE};
    matrix_q[REG_ROW3_C01] = '0;
    matrix_q[REG_ROW3_C23] = {ONE, 32'h0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the first rows run on the reset matrix, without any write.
    cur = MAT_IDENT;
    foreach (directed[i]) begin
      if (directed[i].mat != cur) begin
        cur = directed[i].mat;
        load_named(cur);
      end
      send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].typed,
                 directed[i].ex);
      maybe_pause();
    end

    // Random part: a fresh matrix per phase; the last phase runs without gaps.
    for (int phase = 0; phase < 11; phase++) begin
      foreach (m[i]) m[i] = {rand_coeff(), rand_coeff()};
      if (phase % 4 == 2) begin
        m[REG_ROW3_C01] = '0;
        m[REG_ROW3_C23] = '0;
      end else if (phase % 4 != 3) begin
        // Keep the w row small, with an offset of one to four, so that most quotients stay in range.
        m[REG_ROW3_C01] = {32'($urandom_range(0, 1 << 12) - (1 << 11)),
                           32'($urandom_range(0, 1 << 12) - (1 << 11))};
        m[REG_ROW3_C23] = {32'(ONE * $urandom_range(1, 4) + $urandom_range(0, 255)),
                           32'($urandom_range(0, 1 << 12) - (1 << 11))};
      end
      load_matrix(m);
      calm = (phase == 10);
      for (int n = 0; n < 58; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
        maybe_pause();
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    $display("Sent %0d points over %0d matrix loads; %0d result words checked.",
             points_sent, matrices_loaded, words_checked);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
